FILE: hw/rtl/ipc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_pkg
// Shared sizes, constants and helpers for the isolated pixel counter.
// ----------------------------------------------------------------------------
package ipc_pkg;

    // Largest frame geometry the line buffers are built for.
    localparam int unsigned MAX_ROWS = 128;
    localparam int unsigned MAX_COLS = 128;

    // Position counter widths.
    localparam int unsigned ROW_W = $clog2(MAX_ROWS);
    localparam int unsigned COL_W = $clog2(MAX_COLS);

    // Configuration port widths.
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 8;

    // Result counter width and its saturation point.
    localparam int unsigned              COUNT_W   = 13;
    localparam logic [COUNT_W-1:0]       COUNT_MAX = '1;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_ROWS = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_COLS = CFG_INDEX_W'(1);

    // Turns a written geometry value into the index of the last row or
    // column. Zero is taken as one, and values above the limit as the limit.
    function automatic logic [CFG_DATA_W-1:0] geom_last(
        input logic [CFG_DATA_W-1:0] value,
        input int unsigned           limit
    );
        logic [CFG_DATA_W-1:0] result;
        if (value == '0) begin
            result = '0;
        end else if (32'(value) > limit) begin
            result = CFG_DATA_W'(limit - 1);
        end else begin
            result = value - CFG_DATA_W'(1);
        end
        return result;
    endfunction

endpackage

FILE: hw/rtl/ipc_delay_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_delay_cell
// One stage of a row delay line: holds one pixel and passes it on to the
// next stage each time a pixel is accepted.
// ----------------------------------------------------------------------------
module ipc_delay_cell
    import ipc_pkg::*;
(
    input  logic aclk,
    input  logic shift_en,
    input  logic pixel_in,
    output logic pixel_out
);

    logic pixel_reg;

    // The stored pixel moves on only when the stream advances.
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            pixel_reg <= pixel_in;
        end
    end

    assign pixel_out = pixel_reg;

endmodule

FILE: hw/rtl/ipc_line_buffer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipc_line_buffer
// A chain of delay cells, one per column, that returns the pixel accepted
// exactly one frame row earlier. The tap moves with the configured width.
// ----------------------------------------------------------------------------
module ipc_line_buffer
    import ipc_pkg::*;
(
    input  logic             aclk,
    input  logic             shift_en,
    input  logic             pixel_in,
    input  logic [COL_W-1:0] tap_sel,
    output logic             pixel_out
);

    logic cell_q [MAX_COLS];

    // First cell takes the incoming pixel; every other cell takes its neighbor.
    for (genvar i = 0; i < MAX_COLS; i++) begin : g_cell
        if (i == 0) begin : g_head
            ipc_delay_cell u_cell (
                .aclk      (aclk),
                .shift_en  (shift_en),
                .pixel_in  (pixel_in),
                .pixel_out (cell_q[i])
            );
        end else begin : g_body
            ipc_delay_cell u_cell (
                .aclk      (aclk),
                .shift_en  (shift_en),
                .pixel_in  (cell_q[i-1]),
                .pixel_out (cell_q[i])
            );
        end
    end

    // Cell (width - 1) holds the pixel from width requests ago.
    assign pixel_out = cell_q[tap_sel];

endmodule

FILE: hw/rtl/isolated_pixel_counter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// isolated_pixel_counter_core
// Counts set pixels of a binary frame that have no set pixel among their
// eight neighbors, and reports the count once per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on the s_ channel in raster order, one per request.
//   Frame height and width are written on the cfg_ port (index 0 = rows,
//   index 1 = columns, both 1 to 128; zero is taken as one, larger values
//   as 128). Any accepted write to index 0 or 1 restarts the frame.
//   On the request that carries the last pixel of a frame, one result with
//   the frame's isolated pixel count is issued on the m_ channel; it becomes
//   valid the cycle after that request. No other pixel issues a result.
//   Throughput is one pixel per cycle while s_ready is high: two chains of delay cells hold the
//   two previous rows and a 3x3 window is judged as each pixel arrives.
//   s_ready drops only while a result waits in the output register and
//   m_ready is low; the pixel offered then is held until the result leaves.
//   Reset (aresetn low at a clock edge) sets both dimensions to one and
//   starts a fresh frame; no clearing pass is needed.
// ----------------------------------------------------------------------------
module isolated_pixel_counter_core
    import ipc_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_pixel_is_star,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [COUNT_W-1:0]     m_star_count,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    // Geometry, position and count registers.
    logic [ROW_W-1:0]   rows_last_reg;
    logic [COL_W-1:0]   cols_last_reg;
    logic [ROW_W-1:0]   row_pos_reg;
    logic [COL_W-1:0]   col_pos_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               m_valid_reg;
    logic [COUNT_W-1:0] m_star_count_reg;

    // Window columns one and two back for the rows two back, one back, current.
    logic top_w1_reg, top_w2_reg;
    logic mid_w1_reg, mid_w2_reg;
    logic cur_w1_reg, cur_w2_reg;

    logic in_accept;
    logic cfg_write;
    logic row_end;
    logic frame_last_row;
    logic frame_end;
    logic line1_tap, line2_tap;
    logic top_new, mid_new, cur_new;
    logic iso_mid, iso_mid_edge, iso_cur, iso_cur_edge;
    logic [2:0]         inc;
    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] count_next;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid
                       && ((cfg_index == CFG_FRAME_ROWS) || (cfg_index == CFG_FRAME_COLS));

    assign s_ready   = !m_valid_reg || m_ready;
    assign in_accept = s_valid && s_ready;

    assign row_end        = (col_pos_reg == cols_last_reg);
    assign frame_last_row = (row_pos_reg == rows_last_reg);
    assign frame_end      = row_end && frame_last_row;

    // Two row delay lines: one row back, then two rows back.
    ipc_line_buffer u_line1 (
        .aclk      (aclk),
        .shift_en  (in_accept),
        .pixel_in  (s_pixel_is_star),
        .tap_sel   (cols_last_reg),
        .pixel_out (line1_tap)
    );

    ipc_line_buffer u_line2 (
        .aclk      (aclk),
        .shift_en  (in_accept),
        .pixel_in  (line1_tap),
        .tap_sel   (cols_last_reg),
        .pixel_out (line2_tap)
    );

    // Rows above the frame read as empty; the delay lines are never cleared.
    assign cur_new = s_pixel_is_star;
    assign mid_new = line1_tap && (row_pos_reg >= ROW_W'(1));
    assign top_new = line2_tap && (row_pos_reg >= ROW_W'(2));

    // Pixel one row up and one column left, with all neighbors present.
    assign iso_mid = mid_w1_reg
                     && !(top_w2_reg || top_w1_reg || top_new)
                     && !(mid_w2_reg || mid_new)
                     && !(cur_w2_reg || cur_w1_reg || cur_new);

    // Pixel one row up in the last column: nothing to its right.
    assign iso_mid_edge = row_end && mid_new
                          && !(top_w1_reg || top_new)
                          && !mid_w1_reg
                          && !(cur_w1_reg || cur_new);

    // On the last row, the pixel one column left has nothing below it.
    assign iso_cur = frame_last_row && cur_w1_reg
                     && !(mid_w2_reg || mid_w1_reg || mid_new)
                     && !(cur_w2_reg || cur_new);

    // The very last pixel of the frame: nothing right of it or below it.
    assign iso_cur_edge = frame_end && cur_new
                          && !(mid_w1_reg || mid_new)
                          && !cur_w1_reg;

    // Add this request's finds to the running count, saturating.
    assign inc = 3'(iso_mid) + 3'(iso_mid_edge) + 3'(iso_cur) + 3'(iso_cur_edge);
    assign sum = {1'b0, count_reg} + (COUNT_W+1)'(inc);

    always_comb begin
        if (sum > {1'b0, COUNT_MAX}) begin
            count_next = COUNT_MAX;
        end else begin
            count_next = sum[COUNT_W-1:0];
        end
    end

    // Geometry, raster position, count and result handshake.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_last_reg <= '0;
            cols_last_reg <= '0;
            row_pos_reg   <= '0;
            col_pos_reg   <= '0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else if (cfg_write) begin
            if (cfg_index == CFG_FRAME_ROWS) begin
                rows_last_reg <= ROW_W'(geom_last(cfg_data, MAX_ROWS));
            end else begin
                cols_last_reg <= COL_W'(geom_last(cfg_data, MAX_COLS));
            end
            row_pos_reg <= '0;
            col_pos_reg <= '0;
            count_reg   <= '0;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (in_accept) begin
                if (frame_end) begin
                    row_pos_reg <= '0;
                    col_pos_reg <= '0;
                    count_reg   <= '0;
                    m_valid_reg <= 1'b1;
                end else if (row_end) begin
                    row_pos_reg <= row_pos_reg + ROW_W'(1);
                    col_pos_reg <= '0;
                    count_reg   <= count_next;
                end else begin
                    col_pos_reg <= col_pos_reg + COL_W'(1);
                    count_reg   <= count_next;
                end
            end
        end
    end

    // Result payload is loaded with the final count of the frame.
    always_ff @(posedge aclk) begin
        if (in_accept && frame_end) begin
            m_star_count_reg <= count_next;
        end
    end

    // Window columns shift along the row and empty at the start of each row.
    always_ff @(posedge aclk) begin
        if (!aresetn || cfg_write) begin
            top_w1_reg <= 1'b0;
            top_w2_reg <= 1'b0;
            mid_w1_reg <= 1'b0;
            mid_w2_reg <= 1'b0;
            cur_w1_reg <= 1'b0;
            cur_w2_reg <= 1'b0;
        end else if (in_accept) begin
            if (row_end) begin
                top_w1_reg <= 1'b0;
                top_w2_reg <= 1'b0;
                mid_w1_reg <= 1'b0;
                mid_w2_reg <= 1'b0;
                cur_w1_reg <= 1'b0;
                cur_w2_reg <= 1'b0;
            end else begin
                top_w2_reg <= top_w1_reg;
                top_w1_reg <= top_new;
                mid_w2_reg <= mid_w1_reg;
                mid_w1_reg <= mid_new;
                cur_w2_reg <= cur_w1_reg;
                cur_w1_reg <= cur_new;
            end
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_star_count = m_star_count_reg;

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the isolated pixel counter core. A short table of
// hand-picked requests covers the small frames, zero geometry writes and
// writes in the middle of a frame. Random frames of varied geometry, with
// oversized writes, and pixel density follow. Frame counts are checked
// against typed values or an in-bench predictor of the 8-neighbor isolation
// test, while both sides of the stream idle at random and the receiver once
// holds off long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_top;
    import ipc_pkg::*;

    localparam int unsigned ITEM_TARGET   = 1200;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned BUSY_PCT      = 68;
    localparam int unsigned LIGHT_PCT     = 14;
    localparam longint     LIMIT_NS       = 64'd6_000_000;

    // Index outside the register map; a write to it must change nothing.
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_TOP = '1;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_e;
    typedef enum logic {ROW_PIXEL, ROW_WRITE} row_kind_e;

    typedef struct packed {
        row_kind_e              kind;
        logic [CFG_INDEX_W-1:0] idx;
        logic [CFG_DATA_W-1:0]  data;
        logic                   px;
        logic                   typed;
        logic [COUNT_W-1:0]     want;
    } script_row_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_pixel_is_star;
    logic                   m_valid;
    logic                   m_ready;
    logic [COUNT_W-1:0]     m_star_count;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predictor state: geometry, the three line buffers and the raster position.
    int unsigned          geo_rows;
    int unsigned          geo_cols;
    logic [MAX_COLS-1:0]  line_two_up;
    logic [MAX_COLS-1:0]  line_one_up;
    logic [MAX_COLS-1:0]  line_now;
    int unsigned          cur_row;
    int unsigned          cur_col;
    logic [COUNT_W-1:0]   iso_total;

    logic [COUNT_W-1:0]   pending_counts[$];
    idle_e                idle_mode = IDLE_NONE;
    bit                   hold_off = 1'b0;
    int unsigned          mismatches = 0;
    int unsigned          pixels_sent = 0;

    isolated_pixel_counter_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_pixel_is_star (s_pixel_is_star),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_star_count    (m_star_count),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // A written geometry of zero means one; anything past the buffer size is
    // cut to the buffer size.
    function automatic int unsigned fit_dim(input logic [CFG_DATA_W-1:0] value,
                                            input int unsigned limit);
        if (value == '0) return 1;
        if (int'(value) > limit) return limit;
        return int'(value);
    endfunction

    function automatic void restart_frame();
        line_two_up = '0;
        line_one_up = '0;
        line_now    = '0;
        cur_row     = 0;
        cur_col     = 0;
        iso_total   = '0;
    endfunction

    function automatic void predict_write(input logic [CFG_INDEX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_FRAME_ROWS) begin
            geo_rows = fit_dim(data, MAX_ROWS);
        end else if (idx == CFG_FRAME_COLS) begin
            geo_cols = fit_dim(data, MAX_COLS);
        end else begin
            return;
        end
        restart_frame();
    endfunction

    // Adds the set pixels of the middle line whose 3x3 neighborhood is empty.
    function automatic void tally_line(input logic [MAX_COLS-1:0] up,
                                       input logic [MAX_COLS-1:0] mid,
                                       input logic [MAX_COLS-1:0] down);
        int unsigned c;
        int unsigned k;
        logic        alone;
        for (c = 0; c < geo_cols; c++) begin
            if (mid[c]) begin
                alone = 1'b1;
                for (k = (c == 0) ? 0 : c - 1; k <= c + 1; k++) begin
                    if (k < geo_cols && (up[k] || down[k] || (k != c && mid[k])))
                        alone = 1'b0;
                end
                if (alone && iso_total < COUNT_MAX) iso_total++;
            end
        end
    endfunction

    // Takes one pixel; returns 1 with the frame count when the frame closes.
    function automatic bit raster_step(input logic px,
                                       output logic [COUNT_W-1:0] count);
        int unsigned c;
        c = (cur_col >= geo_cols) ? 0 : cur_col;
        line_now[c] = px;
        if (c + 1 < geo_cols) begin
            cur_col = c + 1;
            return 1'b0;
        end
        if (cur_row >= 1) tally_line(line_two_up, line_one_up, line_now);
        if (cur_row + 1 >= geo_rows) begin
            tally_line(line_one_up, line_now, '0);
            count = iso_total;
            restart_frame();
            return 1'b1;
        end
        line_two_up = line_one_up;
        line_one_up = line_now;
        line_now    = '0;
        cur_row++;
        cur_col = 0;
        return 1'b0;
    endfunction

    function automatic bit sender_rests();
        return (idle_mode == IDLE_SENDER && $urandom_range(99) < BUSY_PCT) ||
               (idle_mode == IDLE_BOTH && $urandom_range(99) < LIGHT_PCT);
    endfunction

    function automatic bit receiver_rests();
        return (idle_mode == IDLE_RECEIVER && $urandom_range(99) < BUSY_PCT) ||
               (idle_mode == IDLE_BOTH && $urandom_range(99) < LIGHT_PCT);
    endfunction

    // Small geometry values, with an occasional zero.
    function automatic logic [CFG_DATA_W-1:0] pick_small(input int unsigned hi);
        if ($urandom_range(9) == 0) return '0;
        return CFG_DATA_W'($urandom_range(hi, 1));
    endfunction

    // Large values: mostly at or beyond the buffer size, sometimes 64 to 127.
    function automatic logic [CFG_DATA_W-1:0] pick_large();
        case ($urandom_range(3))
            0: return CFG_DATA_W'(MAX_COLS);
            1: return '1;
            2: return CFG_DATA_W'($urandom_range(254, 129));
            default: return CFG_DATA_W'($urandom_range(127, 64));
        endcase
    endfunction

    function automatic script_row_t pix(input logic px, input logic typed,
                                        input int unsigned want);
        return '{ROW_PIXEL, '0, '0, px, typed, COUNT_W'(want)};
    endfunction

    function automatic script_row_t wr(input logic [CFG_INDEX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] data);
        return '{ROW_WRITE, idx, data, 1'b0, 1'b0, '0};
    endfunction

    // Stops offering pixels and waits until every frame count is out.
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_counts.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        predict_write(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Sends one pixel request; a typed count replaces the predicted one.
    task automatic push_pixel(input logic px, input logic typed,
                              input logic [COUNT_W-1:0] typed_count);
        logic [COUNT_W-1:0] count;
        while (sender_rests()) begin
            s_valid         <= 1'b0;
            s_pixel_is_star <= 1'($urandom);
            @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_pixel_is_star <= px;
        do @(posedge aclk); while (!s_ready);
        if (raster_step(px, count)) pending_counts.push_back(typed ? typed_count : count);
        pixels_sent++;
        @(negedge aclk);
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin : receiver
        int unsigned wait_left;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off) begin
                m_ready <= 1'b0;
                for (wait_left = HOLD_CYCLES; wait_left != 0; wait_left--)
                    @(negedge aclk);
                hold_off = 1'b0;
            end
            m_ready <= !receiver_rests();
        end
    end

    // Each accepted count is compared with the oldest expected one.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_counts.size() == 0) begin
                $display("%0t: unexpected star_count %0d, none expected",
                         $time, m_star_count);
                mismatches++;
            end else if (pending_counts[0] !== m_star_count) begin
                $display("%0t: star_count expected %0d, got %0d",
                         $time, pending_counts[0], m_star_count);
                mismatches++;
                void'(pending_counts.pop_front());
            end else begin
                void'(pending_counts.pop_front());
            end
        end
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        script_row_t                script[];
        logic [CFG_DATA_W-1:0]      rows_w;
        logic [CFG_DATA_W-1:0]      cols_w;
        int unsigned                phase;
        int unsigned                frame_px;
        int unsigned                frames;
        int unsigned                density;
        int unsigned                f;
        int unsigned                p;
        int unsigned                r;
        bit                         pressure;

        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_pixel_is_star = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        geo_rows = 1;
        geo_cols = 1;
        restart_frame();
        @(negedge aclk);

        // Directed part: tiny frames whose counts are plain to see.
        script = '{
            pix(1, 1, 1), pix(0, 1, 0),                    // 1x1 after reset
            wr(CFG_FRAME_ROWS, 8'd0), wr(CFG_FRAME_COLS, 8'd0),
            pix(1, 1, 1),                                  // zero taken as one
            wr(CFG_FRAME_ROWS, 8'd2), wr(CFG_FRAME_COLS, 8'd2),
            pix(1, 0, 0), pix(0, 0, 0), pix(0, 0, 0), pix(0, 1, 1),
            pix(0, 0, 0), pix(1, 0, 0), pix(1, 0, 0), pix(0, 1, 0), // diagonal pair
            pix(1, 0, 0),
            wr(CFG_UNUSED_TOP, 8'hFF),                     // must not restart
            pix(0, 0, 0), pix(0, 0, 0), pix(0, 1, 1),
            pix(1, 0, 0),
            wr(CFG_FRAME_ROWS, 8'd1),                      // abandons the frame
            pix(1, 0, 0), pix(0, 1, 1),
            wr(CFG_FRAME_COLS, 8'd3),
            pix(1, 0, 0), pix(0, 0, 0), pix(1, 1, 2)
        };
        foreach (script[i]) begin
            if (script[i].kind == ROW_WRITE) begin
                write_reg(script[i].idx, script[i].data);
            end else begin
                push_pixel(script[i].px, script[i].typed, script[i].want);
            end
        end

        // Random part: one geometry and idling pattern per phase. The first
        // four phases always run so that every idling pattern is seen.
        phase = 0;
        while (pixels_sent < ITEM_TARGET || phase < 4) begin
            pressure = (phase == 0);
            r = $urandom_range(9);
            if (pressure) begin
                rows_w = 8'd1;
                cols_w = 8'd1;
            end else if (r == 0) begin
                rows_w = pick_large();
                cols_w = pick_small(2);
            end else if (r == 1) begin
                rows_w = pick_small(3);
                cols_w = pick_large();
            end else begin
                rows_w = pick_small(8);
                cols_w = pick_small(12);
            end
            if ($urandom_range(1) == 0) begin
                write_reg(CFG_FRAME_ROWS, rows_w);
                write_reg(CFG_FRAME_COLS, cols_w);
            end else begin
                write_reg(CFG_FRAME_COLS, cols_w);
                write_reg(CFG_FRAME_ROWS, rows_w);
            end
            if ($urandom_range(3) == 0)
                write_reg(CFG_INDEX_W'($urandom_range(255, 2)), CFG_DATA_W'($urandom));

            idle_mode = pressure ? IDLE_NONE : idle_e'(phase % 4);
            frame_px  = fit_dim(rows_w, MAX_ROWS) * fit_dim(cols_w, MAX_COLS);
            frames    = 320 / frame_px;
            if (frames == 0) frames = 1;
            if (frames > 12) frames = 12;
            if (pressure) begin
                frames   = 40;
                hold_off = 1'b1;
            end

            for (f = 0; f < frames; f++) begin
                case ($urandom_range(4))
                    0: density = 5;
                    1: density = 15;
                    2: density = 30;
                    3: density = 50;
                    default: density = 90;
                endcase
                for (p = 0; p < frame_px; p++)
                    push_pixel($urandom_range(99) < density, 1'b0, '0);
            end

            // Sometimes leave a frame half done for the next write to abandon.
            if (frame_px > 1 && $urandom_range(3) == 0) begin
                for (p = $urandom_range(frame_px - 1, 1); p != 0; p--)
                    push_pixel(1'($urandom), 1'b0, '0);
            end
            phase++;
        end

        settle();
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/ipc_pkg.sv
hw/rtl/ipc_delay_cell.sv
hw/rtl/ipc_line_buffer.sv
hw/rtl/isolated_pixel_counter_core.sv
tb/sv/tb_top.sv
